/* src/wpb_pkg.sv */
// ----------------------------------------------------------------------------
// Weighted pixel blender package
// Shared types, register codes and sizing constants for the blender block.
// ----------------------------------------------------------------------------
package wpb_pkg;

    // Contributions beyond this count per output pixel are ignored.
    localparam int MAX_IMAGES = 16;
    localparam int CNT_W      = $clog2(MAX_IMAGES + 1);

    localparam int CH_W     = 8;
    localparam int BW_W     = 24;
    localparam int PROD_W   = BW_W + CH_W;
    localparam int ACC_W    = 36;
    localparam int WACC_W   = 28;
    localparam int NUM_W    = ACC_W + 1;
    localparam int DEN_W    = WACC_W + 1;

    // The quotient never exceeds 255, so eight restoring steps suffice.
    localparam int DIV_STEPS = CH_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int DSH_W     = DEN_W + DIV_STEPS - 1;

    localparam logic [CH_W-1:0] OPAQUE          = 8'd255;
    localparam logic [CH_W-1:0] THRESHOLD_RESET = 8'd127;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IGNORE_MODE = 1'b0;
    localparam logic REG_ALPHA_THR   = 1'b1;

    typedef struct packed {
        logic signed [15:0] local_x;
        logic signed [15:0] local_y;
        logic [13:0]        img_width;
        logic [13:0]        img_height;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic [7:0]         alpha_in;
        logic [23:0]        blend_weight;
        logic               last_image;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       covered;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic accumulate;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic item_last;
    } status_t;

endpackage

/* src/wpb_regs.sv */
// ----------------------------------------------------------------------------
// Weighted pixel blender configuration registers
// APB-style register file holding the blend mode and the alpha threshold.
// ----------------------------------------------------------------------------
module wpb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wpb_pkg::PADDR_W-1:0] paddr,
    input  logic [wpb_pkg::PDATA_W-1:0] pwdata,
    output logic [wpb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic                        ignore_mode,
    output logic [wpb_pkg::CH_W-1:0]    alpha_thr
);
    import wpb_pkg::*;

    logic            mode_reg, mode_next;
    logic [CH_W-1:0] thr_reg, thr_next;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        mode_next = mode_reg;
        thr_next  = thr_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_IGNORE_MODE: mode_next = pwdata[0];
                REG_ALPHA_THR:   thr_next  = pwdata[CH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IGNORE_MODE: prdata = {{(PDATA_W-1){1'b0}}, mode_reg};
            REG_ALPHA_THR:   prdata = {{(PDATA_W-CH_W){1'b0}}, thr_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            thr_reg  <= THRESHOLD_RESET;
        end else begin
            mode_reg <= mode_next;
            thr_reg  <= thr_next;
        end
    end

    assign ignore_mode = mode_reg;
    assign alpha_thr   = thr_reg;

endmodule

/* src/wpb_ctrl.sv */
// ----------------------------------------------------------------------------
// Weighted pixel blender controller
// Sequences capture, accumulation, division and result hand-off.
// ----------------------------------------------------------------------------
module wpb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  wpb_pkg::status_t status,
    output wpb_pkg::cmd_t    cmd
);
    import wpb_pkg::*;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_ACC;
            ST_ACC:   state_next = status.item_last ? ST_DLOAD : ST_IDLE;
            ST_DLOAD: state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_ACC:   cmd.accumulate = 1'b1;
            ST_DLOAD: cmd.div_load   = 1'b1;
            ST_DIV:   cmd.div_step   = 1'b1;
            ST_OUT:   cmd.out_load   = out_free;
            default: ;
        endcase
    end

    always_comb begin
        cnt_next = (state_reg == ST_DIV) ? cnt_reg + 1'b1 : '0;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* src/wpb_datapath.sv */
// ----------------------------------------------------------------------------
// Weighted pixel blender datapath
// Weight selection, multiply-accumulate and three restoring dividers.
// ----------------------------------------------------------------------------
module wpb_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  wpb_pkg::cmd_t            cmd,
    input  wpb_pkg::in_item_t        s_data,
    input  logic                     ignore_mode,
    input  logic [wpb_pkg::CH_W-1:0] alpha_thr,
    output wpb_pkg::status_t         status,
    output wpb_pkg::out_item_t       m_data
);
    import wpb_pkg::*;

    // Captured contribution
    logic [BW_W-1:0]   wt_reg, wt_next;
    logic [PROD_W-1:0] pr_reg, pg_reg, pb_reg, pr_next, pg_next, pb_next;
    logic              take_reg, take_next;
    logic              last_reg, last_next;

    // Per-pixel accumulators
    logic [ACC_W-1:0]  racc_reg, gacc_reg, bacc_reg, racc_next, gacc_next, bacc_next;
    logic [WACC_W-1:0] wacc_reg, wacc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Dividers
    logic [NUM_W-1:0]  rrem_reg, grem_reg, brem_reg, rrem_next, grem_next, brem_next;
    logic [DSH_W-1:0]  dsh_reg, dsh_next;
    logic [CH_W-1:0]   rq_reg, gq_reg, bq_reg, rq_next, gq_next, bq_next;
    logic              cov_reg, cov_next;

    out_item_t         out_reg, out_next;

    logic              in_image;
    logic [BW_W-1:0]   wt_sel;
    logic [WACC_W:0]   wsum;
    logic              r_ge, g_ge, b_ge;
    logic [DEN_W-1:0]  den;

    // A coordinate counts when it is non-negative and below the image size.
    assign in_image = !s_data.local_x[15] && !s_data.local_y[15]
                   && (s_data.local_x[14:0] < {1'b0, s_data.img_width})
                   && (s_data.local_y[14:0] < {1'b0, s_data.img_height});

    always_comb begin
        if (ignore_mode) begin
            wt_sel = (s_data.alpha_in > alpha_thr) ? BW_W'(1) : '0;
        end else begin
            wt_sel = s_data.blend_weight;
        end
    end

    assign wsum = {1'b0, wacc_reg} + (WACC_W + 1)'(wt_reg);
    assign den  = {wacc_reg, 1'b0};

    assign r_ge = rrem_reg >= NUM_W'(dsh_reg);
    assign g_ge = grem_reg >= NUM_W'(dsh_reg);
    assign b_ge = brem_reg >= NUM_W'(dsh_reg);

    always_comb begin
        wt_next   = wt_reg;
        pr_next   = pr_reg;
        pg_next   = pg_reg;
        pb_next   = pb_reg;
        take_next = take_reg;
        last_next = last_reg;
        racc_next = racc_reg;
        gacc_next = gacc_reg;
        bacc_next = bacc_reg;
        wacc_next = wacc_reg;
        cnt_next  = cnt_reg;
        rrem_next = rrem_reg;
        grem_next = grem_reg;
        brem_next = brem_reg;
        dsh_next  = dsh_reg;
        rq_next   = rq_reg;
        gq_next   = gq_reg;
        bq_next   = bq_reg;
        cov_next  = cov_reg;
        out_next  = out_reg;

        if (cmd.capture) begin
            wt_next   = wt_sel;
            pr_next   = wt_sel * s_data.red_in;
            pg_next   = wt_sel * s_data.green_in;
            pb_next   = wt_sel * s_data.blue_in;
            take_next = in_image && (wt_sel != '0);
            last_next = s_data.last_image;
        end

        if (cmd.accumulate && (cnt_reg < CNT_W'(MAX_IMAGES))) begin
            cnt_next = cnt_reg + 1'b1;
            // A contribution that would overflow the total weight is dropped whole.
            if (take_reg && !wsum[WACC_W]) begin
                wacc_next = wsum[WACC_W-1:0];
                racc_next = racc_reg + ACC_W'(pr_reg);
                gacc_next = gacc_reg + ACC_W'(pg_reg);
                bacc_next = bacc_reg + ACC_W'(pb_reg);
            end
        end

        // Mean rounded half up: floor((2*acc + W) / (2*W)).
        if (cmd.div_load) begin
            rrem_next = {racc_reg, 1'b0} + NUM_W'(wacc_reg);
            grem_next = {gacc_reg, 1'b0} + NUM_W'(wacc_reg);
            brem_next = {bacc_reg, 1'b0} + NUM_W'(wacc_reg);
            dsh_next  = {den, {(DIV_STEPS-1){1'b0}}};
            rq_next   = '0;
            gq_next   = '0;
            bq_next   = '0;
            cov_next  = wacc_reg != '0;
            racc_next = '0;
            gacc_next = '0;
            bacc_next = '0;
            wacc_next = '0;
            cnt_next  = '0;
        end

        if (cmd.div_step) begin
            if (r_ge) rrem_next = rrem_reg - NUM_W'(dsh_reg);
            if (g_ge) grem_next = grem_reg - NUM_W'(dsh_reg);
            if (b_ge) brem_next = brem_reg - NUM_W'(dsh_reg);
            rq_next  = {rq_reg[CH_W-2:0], r_ge};
            gq_next  = {gq_reg[CH_W-2:0], g_ge};
            bq_next  = {bq_reg[CH_W-2:0], b_ge};
            dsh_next = dsh_reg >> 1;
        end

        if (cmd.out_load) begin
            out_next.red_out   = cov_reg ? rq_reg : '0;
            out_next.green_out = cov_reg ? gq_reg : '0;
            out_next.blue_out  = cov_reg ? bq_reg : '0;
            out_next.alpha_out = cov_reg ? OPAQUE : '0;
            out_next.covered   = cov_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            racc_reg <= '0;
            gacc_reg <= '0;
            bacc_reg <= '0;
            wacc_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            racc_reg <= racc_next;
            gacc_reg <= gacc_next;
            bacc_reg <= bacc_next;
            wacc_reg <= wacc_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        wt_reg   <= wt_next;
        pr_reg   <= pr_next;
        pg_reg   <= pg_next;
        pb_reg   <= pb_next;
        take_reg <= take_next;
        last_reg <= last_next;
        rrem_reg <= rrem_next;
        grem_reg <= grem_next;
        brem_reg <= brem_next;
        dsh_reg  <= dsh_next;
        rq_reg   <= rq_next;
        gq_reg   <= gq_next;
        bq_reg   <= bq_next;
        cov_reg  <= cov_next;
        out_reg  <= out_next;
    end

    assign status.item_last = last_reg;
    assign m_data           = out_reg;

endmodule

/* src/weighted_pixel_blender_unit.sv */
// ----------------------------------------------------------------------------
// Weighted pixel blender
// Blends one contribution per source image into a weighted-mean output pixel.
// ----------------------------------------------------------------------------
// A contribution that does not close a pixel is accepted and its weighted
// channels are multiplied into registers, then added to the accumulators
// in the next cycle. The contribution marked last then goes on to load the
// dividers, takes 8 restoring division steps (one quotient bit per cycle for
// each channel) and places the item in the output register once that
// register is no longer held by the sink.
// A finished item waits in the output register while the next one is taken.
module weighted_pixel_blender_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  wpb_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output wpb_pkg::out_item_t          m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wpb_pkg::PADDR_W-1:0] paddr,
    input  logic [wpb_pkg::PDATA_W-1:0] pwdata,
    output logic [wpb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import wpb_pkg::*;

    cmd_t            cmd;
    status_t         status;
    logic            ignore_mode;
    logic [CH_W-1:0] alpha_thr;

    wpb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .ignore_mode (ignore_mode),
        .alpha_thr   (alpha_thr)
    );

    wpb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wpb_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_data      (s_data),
        .ignore_mode (ignore_mode),
        .alpha_thr   (alpha_thr),
        .status      (status),
        .m_data      (m_data)
    );

endmodule

/* dv/tb_weighted_pixel_blender_unit.sv */
// ----------------------------------------------------------------------------
// Weighted pixel blender testbench
// Drives runs of per-image contributions into the blender, predicts each
// blended output pixel alongside the block and compares every result field
// by field. Covers both weighting modes, the coverage edge cases, overlong
// runs, output backpressure and randomized idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_weighted_pixel_blender_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import wpb_pkg::*;

    localparam logic [63:0] WEIGHT_LIMIT = (64'd1 << WACC_W) - 64'd1;
    localparam int SETTLE_CYCLES = 16;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Predictor state for the pixel being built.
    logic                cfg_ignore_mode = 1'b0;
    logic [7:0]          cfg_threshold   = THRESHOLD_RESET;
    logic [63:0]         acc_red    = '0;
    logic [63:0]         acc_green  = '0;
    logic [63:0]         acc_blue   = '0;
    logic [63:0]         acc_weight = '0;
    int                  contrib_count = 0;
    out_item_t           pending_pixels[$];

    int                  mismatch_count = 0;
    int                  send_gap_max   = 6;
    int                  sink_stall_max = 6;
    int                  sink_hold      = 0;

    weighted_pixel_blender_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [7:0] rounded_mean(input logic [63:0] sum,
                                                input logic [63:0] total);
        logic [63:0] q;
        q = (2 * sum + total) / (2 * total);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Folds one accepted contribution into the pixel and, on the last one,
    // queues the blended pixel that the block must produce.
    task automatic blend_accumulate(input in_item_t c);
        int          px, py, pw, ph;
        bit          in_image;
        logic [63:0] wt;
        out_item_t   pixel;
        px = int'(c.local_x);
        py = int'(c.local_y);
        pw = int'(c.img_width);
        ph = int'(c.img_height);
        in_image = px >= 0 && px < pw && py >= 0 && py < ph;
        if (contrib_count < MAX_IMAGES) begin
            contrib_count++;
            if (in_image) begin
                if (cfg_ignore_mode)
                    wt = (c.alpha_in > cfg_threshold) ? 64'd1 : 64'd0;
                else
                    wt = 64'(c.blend_weight);
                if (wt != 0 && acc_weight + wt <= WEIGHT_LIMIT) begin
                    acc_weight += wt;
                    acc_red    += wt * c.red_in;
                    acc_green  += wt * c.green_in;
                    acc_blue   += wt * c.blue_in;
                end
            end
        end
        if (c.last_image) begin
            pixel = '0;
            if (acc_weight != 0) begin
                pixel.red_out   = rounded_mean(acc_red, acc_weight);
                pixel.green_out = rounded_mean(acc_green, acc_weight);
                pixel.blue_out  = rounded_mean(acc_blue, acc_weight);
                pixel.alpha_out = OPAQUE;
                pixel.covered   = 1'b1;
            end
            pending_pixels.push_back(pixel);
            acc_red = '0;
            acc_green = '0;
            acc_blue = '0;
            acc_weight = '0;
            contrib_count = 0;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            blend_accumulate(s_data);
    end

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with none pending", 64'(m_data), 64'd0);
            end else begin
                want = pending_pixels.pop_front();
                if (m_data.red_out !== want.red_out)
                    report_mismatch("red_out", 64'(m_data.red_out),
                                    64'(want.red_out));
                if (m_data.green_out !== want.green_out)
                    report_mismatch("green_out", 64'(m_data.green_out),
                                    64'(want.green_out));
                if (m_data.blue_out !== want.blue_out)
                    report_mismatch("blue_out", 64'(m_data.blue_out),
                                    64'(want.blue_out));
                if (m_data.alpha_out !== want.alpha_out)
                    report_mismatch("alpha_out", 64'(m_data.alpha_out),
                                    64'(want.alpha_out));
                if (m_data.covered !== want.covered)
                    report_mismatch("covered", 64'(m_data.covered),
                                    64'(want.covered));
            end
        end
    end

    // Result sink: random stalls before each item, plus long holds on request.
    initial begin : result_sink
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
            end
            stall = $urandom_range(0, sink_stall_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready) && sink_hold == 0);
        end
    end

    // Valid is left high after an accept so that a zero-gap item follows
    // without a bubble; stop_sending lowers it at the end of a burst.
    task automatic send_contrib(input in_item_t c);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
    endtask

    // The wait starts on a clock edge, so that the last accepted item has reached the predictor.
    task automatic wait_idle();
        @(posedge aclk);
        wait (pending_pixels.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_reg(input logic reg_idx);
        logic [PDATA_W-1:0] got, want;
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'({reg_idx, 2'b00});
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        want = (reg_idx == REG_IGNORE_MODE) ? PDATA_W'(cfg_ignore_mode)
                                            : PDATA_W'(cfg_threshold);
        if (got !== want)
            report_mismatch("register readback", 64'(got), 64'(want));
    endtask

    task automatic write_reg(input logic reg_idx, input logic [PDATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_IGNORE_MODE)
            cfg_ignore_mode = value[0];
        else
            cfg_threshold = value[7:0];
        check_reg(reg_idx);
    endtask

    // Upper bits carry noise; the block keeps only the register's own width.
    task automatic set_blend_mode(input logic ignore_mode, input logic [7:0] thr);
        write_reg(REG_IGNORE_MODE, ($urandom & ~32'h1) | PDATA_W'(ignore_mode));
        write_reg(REG_ALPHA_THR, ($urandom & ~32'hFF) | PDATA_W'(thr));
    endtask

    function automatic in_item_t contrib(input int x, input int y, input int w,
                                         input int h, input int r, input int g,
                                         input int b, input int a, input int wt,
                                         input bit last);
        in_item_t c;
        c.local_x      = 16'(x);
        c.local_y      = 16'(y);
        c.img_width    = 14'(w);
        c.img_height   = 14'(h);
        c.red_in       = 8'(r);
        c.green_in     = 8'(g);
        c.blue_in      = 8'(b);
        c.alpha_in     = 8'(a);
        c.blend_weight = 24'(wt);
        c.last_image   = last;
        return c;
    endfunction

    function automatic logic [15:0] random_coord(input int size);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7 && size > 0)
            return 16'($urandom_range(0, size - 1));
        if (pick < 8)
            return 16'(size);
        if (pick < 9)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic int random_size();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return 8192;
        return $urandom_range(1, 8192);
    endfunction

    function automatic in_item_t random_contrib(input bit last);
        in_item_t c;
        int w, h, pick;
        w = random_size();
        h = random_size();
        c.img_width  = 14'(w);
        c.img_height = 14'(h);
        c.local_x    = random_coord(w);
        c.local_y    = random_coord(h);
        c.red_in     = 8'($urandom_range(0, 255));
        c.green_in   = 8'($urandom_range(0, 255));
        c.blue_in    = 8'($urandom_range(0, 255));
        c.alpha_in   = 8'($urandom_range(0, 255));
        // Alpha right around the threshold exercises the strict comparison.
        if ($urandom_range(0, 3) == 0)
            c.alpha_in = 8'(int'(cfg_threshold) + $urandom_range(0, 2) - 1);
        pick = $urandom_range(0, 5);
        case (pick)
            0, 1: c.blend_weight = 24'($urandom);
            2, 3: c.blend_weight = 24'($urandom_range(0, 255));
            4: c.blend_weight = 24'hFFFFFF;
            default: c.blend_weight = 24'd0;
        endcase
        c.last_image = last;
        return c;
    endfunction

    task automatic test_directed_mask();
        wait_idle();
        send_gap_max = 6;
        sink_stall_max = 6;
        // A lone contribution with weight one passes its color through.
        send_contrib(contrib(3, 4, 10, 10, 0, 255, 128, 9, 1, 1'b1));
        // Nothing inside any image gives an uncovered, all-zero pixel.
        send_contrib(contrib(-1, 0, 10, 10, 50, 60, 70, 80, 5, 1'b1));
        // Coordinates at and past each edge, empty images and zero weight.
        send_contrib(contrib(-32768, -32768, 8192, 8192, 255, 255, 255, 255, 7, 1'b0));
        send_contrib(contrib(32767, 32767, 8192, 8192, 255, 0, 255, 0, 7, 1'b0));
        send_contrib(contrib(8191, 8191, 8192, 8192, 200, 100, 50, 0, 16777215, 1'b0));
        send_contrib(contrib(0, 0, 0, 5, 255, 255, 255, 255, 9, 1'b0));
        send_contrib(contrib(5, 2, 5, 5, 1, 2, 3, 4, 9, 1'b0));
        send_contrib(contrib(2, 0, 5, 0, 1, 2, 3, 4, 9, 1'b0));
        send_contrib(contrib(1, 1, 5, 5, 255, 255, 255, 255, 0, 1'b0));
        send_contrib(contrib(4, 4, 5, 5, 10, 20, 30, 40, 1, 1'b1));
        // Mean of one half rounds up.
        send_contrib(contrib(0, 0, 1, 1, 0, 1, 2, 0, 1, 1'b0));
        send_contrib(contrib(0, 0, 1, 1, 1, 2, 3, 0, 1, 1'b1));
        // Full weights on more images than the block keeps; the extra
        // contribution is dropped but its last mark still closes the pixel.
        for (int i = 0; i < MAX_IMAGES; i++)
            send_contrib(contrib(i, i, 64, 64, 255 - i, i * 16, 255, 0,
                                 16777215, 1'b0));
        send_contrib(contrib(0, 0, 64, 64, 0, 255, 0, 255, 16777215, 1'b1));
        stop_sending();
    endtask

    task automatic test_directed_ignore();
        wait_idle();
        set_blend_mode(1'b1, 8'd127);
        send_contrib(contrib(0, 0, 4, 4, 255, 255, 255, 127, 0, 1'b0));
        send_contrib(contrib(1, 1, 4, 4, 10, 20, 30, 128, 0, 1'b1));
        stop_sending();
        wait_idle();
        set_blend_mode(1'b1, 8'd0);
        send_contrib(contrib(0, 0, 4, 4, 255, 255, 255, 0, 99, 1'b0));
        send_contrib(contrib(1, 1, 4, 4, 0, 7, 200, 1, 99, 1'b1));
        stop_sending();
        wait_idle();
        set_blend_mode(1'b1, 8'd255);
        send_contrib(contrib(0, 0, 4, 4, 9, 9, 9, 255, 99, 1'b1));
        stop_sending();
    endtask

    // Hold the result channel for a long stretch while short pixels keep
    // arriving back to back, so the block fills and stalls its input.
    task automatic test_output_backpressure();
        int len;
        wait_idle();
        set_blend_mode(1'b0, 8'd127);
        send_gap_max = 0;
        sink_stall_max = 0;
        sink_hold = 120;
        for (int p = 0; p < 30; p++) begin
            len = $urandom_range(1, 2);
            for (int i = 0; i < len; i++)
                send_contrib(random_contrib(i == len - 1));
        end
        stop_sending();
        sink_stall_max = 6;
    endtask

    task automatic test_random_blend();
        int sent, len;
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            case (phase)
                0: set_blend_mode(1'b0, 8'($urandom));
                1: set_blend_mode(1'b1, 8'd0);
                2: set_blend_mode(1'b1, 8'd255);
                3: set_blend_mode(1'b0, 8'($urandom));
                4: set_blend_mode(1'b1, 8'($urandom));
                default: set_blend_mode(1'b1, THRESHOLD_RESET);
            endcase
            case (phase)
                1: begin send_gap_max = 0; sink_stall_max = 0; end
                2: begin send_gap_max = 6; sink_stall_max = 0; end
                3: begin send_gap_max = 0; sink_stall_max = 6; end
                5: begin send_gap_max = 3; sink_stall_max = 3; end
                default: begin send_gap_max = 6; sink_stall_max = 6; end
            endcase
            sent = 0;
            while (sent < 95) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20)
                                                  : $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_contrib(random_contrib(i == len - 1));
                sent += len;
            end
            stop_sending();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_reg(REG_IGNORE_MODE);
        check_reg(REG_ALPHA_THR);
        test_directed_mask();
        test_directed_ignore();
        test_output_backpressure();
        test_random_blend();
        wait_idle();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* weighted_pixel_blender_unit.f */
src/wpb_pkg.sv
src/wpb_regs.sv
src/wpb_ctrl.sv
src/wpb_datapath.sv
src/weighted_pixel_blender_unit.sv
dv/tb_weighted_pixel_blender_unit.sv
